// ===== sv/scfp_pkg.sv =====
`default_nettype none
package scfp_pkg;

  localparam logic [7:0] CH_CONNECT = 8'h53;
  localparam logic [7:0] CH_OPEN    = 8'h5b;
  localparam logic [7:0] CH_CLOSE   = 8'h5d;
  localparam logic [7:0] CH_SEMI    = 8'h3b;
  localparam logic [7:0] CH_ROW_BASE = 8'h30;
  localparam logic [7:0] CH_ROW1    = CH_ROW_BASE + 8'd1;
  localparam logic [7:0] CH_ROW2    = CH_ROW_BASE + 8'd2;
  localparam logic [7:0] CH_MAX7    = 8'h7f;
  localparam logic [7:0] CH_DRIVE   = 8'h44;
  localparam logic [7:0] CH_TEXT    = 8'h54;
  localparam logic [7:0] CH_RESET   = 8'h52;

  localparam logic [7:0] DIR_F = 8'h66;
  localparam logic [7:0] DIR_R = 8'h72;
  localparam logic [7:0] DIR_B = 8'h62;
  localparam logic [7:0] DIR_L = 8'h6c;
  localparam logic [7:0] DIR_T = 8'h74;
  localparam logic [7:0] DIR_S = 8'h73;

  localparam logic [3:0] DRV_FF = 4'd0;
  localparam logic [3:0] DRV_FR = 4'd1;
  localparam logic [3:0] DRV_RR = 4'd2;
  localparam logic [3:0] DRV_BR = 4'd3;
  localparam logic [3:0] DRV_BB = 4'd4;
  localparam logic [3:0] DRV_BL = 4'd5;
  localparam logic [3:0] DRV_LL = 4'd6;
  localparam logic [3:0] DRV_FL = 4'd7;
  localparam logic [3:0] DRV_TR = 4'd8;
  localparam logic [3:0] DRV_TL = 4'd9;
  localparam logic [3:0] DRV_SS = 4'd10;
  localparam logic [3:0] NO_CODE = 4'd15;
  localparam logic [7:0] NUM_CODES = 8'd11;

  typedef enum logic [2:0] {
    KIND_CONNECTED = 3'd0,
    KIND_DRIVE     = 3'd1,
    KIND_TEXT      = 3'd2,
    KIND_ERROR     = 3'd3,
    KIND_RESET     = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_CONNECT,
    ST_IDLE,
    ST_D_OPEN,
    ST_D_FIRST,
    ST_D_SECOND,
    ST_D_CLOSE,
    ST_T_OPEN,
    ST_T_ROW,
    ST_T_SEMI,
    ST_T_CHARS,
    ST_T_CLOSE,
    ST_EMIT,
    ST_HALT
  } state_t;

  typedef struct packed {
    logic  load_first;
    logic  load_code;
    logic  load_row;
    logic  clr_count;
    logic  wr_char;
    logic  emit_step;
    logic  out_load;
    kind_t out_kind;
  } cmd_t;

  typedef struct packed {
    logic is_connect;
    logic is_drive;
    logic is_text;
    logic is_reset;
    logic is_open;
    logic is_close;
    logic is_semi;
    logic row_ok;
    logic high_bit;
    logic code_ok;
    logic line_full;
    logic emit_last;
    logic out_free;
  } stat_t;

  function automatic logic [3:0] drive_decode(input logic [7:0] a, input logic [7:0] b);
    logic [3:0] code;
    unique case ({a, b})
      {DIR_F, DIR_F}: code = DRV_FF;
      {DIR_F, DIR_R}: code = DRV_FR;
      {DIR_R, DIR_R}: code = DRV_RR;
      {DIR_B, DIR_R}: code = DRV_BR;
      {DIR_B, DIR_B}: code = DRV_BB;
      {DIR_B, DIR_L}: code = DRV_BL;
      {DIR_L, DIR_L}: code = DRV_LL;
      {DIR_F, DIR_L}: code = DRV_FL;
      {DIR_T, DIR_R}: code = DRV_TR;
      {DIR_T, DIR_L}: code = DRV_TL;
      {DIR_S, DIR_S}: code = DRV_SS;
      default:        code = NO_CODE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

// ===== sv/serial_command_frame_parser_core.sv =====
// A single result is valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle while the result register drains.
// A text frame's closing ']' starts LINE_CHARS results, one per cycle as
// out_ready allows, from the line buffer's single read port; input waits.
// Reset (rst_n low, synchronous) returns to waiting for the connect byte;
// the line buffer is not cleared, every entry is written before it is read.
`default_nettype none
module serial_command_frame_parser_core #(
  parameter int LINE_CHARS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_event_kind,
  output logic [3:0]      out_drive_code,
  output logic            out_row_index,
  output logic [3:0]      out_column,
  output logic [6:0]      out_text_char,
  output logic            out_last
);

  scfp_pkg::cmd_t  cmd;
  scfp_pkg::stat_t stat;

  scfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  scfp_dpath #(
    .LINE_CHARS(LINE_CHARS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_rx_byte     (in_rx_byte),
    .out_ready      (out_ready),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_event_kind (out_event_kind),
    .out_drive_code (out_drive_code),
    .out_row_index  (out_row_index),
    .out_column     (out_column),
    .out_text_char  (out_text_char),
    .out_last       (out_last)
  );

  a_last_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == scfp_pkg::KIND_TEXT && out_last
      |-> out_column == 4'(LINE_CHARS - 1))
    else $error("text burst ends at wrong column");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != scfp_pkg::KIND_TEXT |-> out_last)
    else $error("single result without last");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != scfp_pkg::KIND_DRIVE |-> out_drive_code == 4'd0)
    else $error("drive code on non-drive result");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

endmodule
`default_nettype wire

// ===== sv/scfp_ram.sv =====
`default_nettype none
module scfp_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/scfp_ctrl.sv =====
`default_nettype none
module scfp_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire scfp_pkg::stat_t stat,
  output scfp_pkg::cmd_t       cmd
);

  scfp_pkg::state_t state_r, state_nxt;
  logic acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scfp_pkg::ST_CONNECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.out_kind = scfp_pkg::KIND_ERROR;
    unique case (state_r)
      scfp_pkg::ST_HALT: in_ready = 1'b1;
      scfp_pkg::ST_EMIT: in_ready = 1'b0;
      default:           in_ready = stat.out_free;
    endcase
    acc = in_valid && in_ready;
    unique case (state_r)
      scfp_pkg::ST_CONNECT: begin
        if (acc && stat.is_connect) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = scfp_pkg::KIND_CONNECTED;
          state_nxt = scfp_pkg::ST_IDLE;
        end
      end
      scfp_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (stat.is_drive) begin
            state_nxt = scfp_pkg::ST_D_OPEN;
          end else if (stat.is_text) begin
            state_nxt = scfp_pkg::ST_T_OPEN;
          end else if (stat.is_reset) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = scfp_pkg::KIND_RESET;
            state_nxt = scfp_pkg::ST_HALT;
          end else begin
            state_nxt = scfp_pkg::ST_IDLE;
          end
        end
      end
      scfp_pkg::ST_D_OPEN: begin
        if (acc) begin
          if (stat.is_open) begin
            state_nxt = scfp_pkg::ST_D_FIRST;
          end else begin
            cmd.out_load = 1'b1;
            state_nxt = scfp_pkg::ST_IDLE;
          end
        end
      end
      scfp_pkg::ST_D_FIRST: begin
        if (acc) begin
          cmd.load_first = 1'b1;
          state_nxt = scfp_pkg::ST_D_SECOND;
        end
      end
      scfp_pkg::ST_D_SECOND: begin
        if (acc) begin
          cmd.load_code = 1'b1;
          state_nxt = scfp_pkg::ST_D_CLOSE;
        end
      end
      scfp_pkg::ST_D_CLOSE: begin
        if (acc) begin
          cmd.out_load = 1'b1;
          if (stat.is_close && stat.code_ok) begin
            cmd.out_kind = scfp_pkg::KIND_DRIVE;
          end
          state_nxt = scfp_pkg::ST_IDLE;
        end
      end
      scfp_pkg::ST_T_OPEN: begin
        if (acc) begin
          state_nxt = stat.is_open ? scfp_pkg::ST_T_ROW : scfp_pkg::ST_IDLE;
        end
      end
      scfp_pkg::ST_T_ROW: begin
        if (acc) begin
          if (stat.row_ok) begin
            cmd.load_row = 1'b1;
            state_nxt = scfp_pkg::ST_T_SEMI;
          end else begin
            cmd.out_load = 1'b1;
            state_nxt = scfp_pkg::ST_IDLE;
          end
        end
      end
      scfp_pkg::ST_T_SEMI: begin
        if (acc) begin
          if (stat.is_semi) begin
            cmd.clr_count = 1'b1;
            state_nxt = scfp_pkg::ST_T_CHARS;
          end else begin
            cmd.out_load = 1'b1;
            state_nxt = scfp_pkg::ST_IDLE;
          end
        end
      end
      scfp_pkg::ST_T_CHARS: begin
        if (acc) begin
          if (stat.high_bit) begin
            cmd.out_load = 1'b1;
            state_nxt = scfp_pkg::ST_IDLE;
          end else begin
            cmd.wr_char = 1'b1;
            if (stat.line_full) begin
              state_nxt = scfp_pkg::ST_T_CLOSE;
            end
          end
        end
      end
      scfp_pkg::ST_T_CLOSE: begin
        if (acc) begin
          if (stat.is_close) begin
            state_nxt = scfp_pkg::ST_EMIT;
          end else begin
            cmd.out_load = 1'b1;
            state_nxt = scfp_pkg::ST_IDLE;
          end
        end
      end
      scfp_pkg::ST_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.emit_step = 1'b1;
          cmd.out_kind = scfp_pkg::KIND_TEXT;
          if (stat.emit_last) begin
            state_nxt = scfp_pkg::ST_IDLE;
          end
        end
      end
      scfp_pkg::ST_HALT: begin
        state_nxt = scfp_pkg::ST_HALT;
      end
      default: begin
        state_nxt = scfp_pkg::ST_HALT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/scfp_dpath.sv =====
`default_nettype none
module scfp_dpath #(
  parameter int LINE_CHARS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     in_rx_byte,
  input  wire logic           out_ready,
  input  wire scfp_pkg::cmd_t cmd,
  output scfp_pkg::stat_t     stat,
  output logic                out_valid,
  output logic [2:0]          out_event_kind,
  output logic [3:0]          out_drive_code,
  output logic                out_row_index,
  output logic [3:0]          out_column,
  output logic [6:0]          out_text_char,
  output logic                out_last
);

  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int CW = (AW < 4) ? AW : 4;
  localparam logic [AW-1:0] LAST_IDX = AW'(LINE_CHARS - 1);

  logic [7:0]    first_r;
  logic          row_r;
  logic [AW-1:0] count_r;
  logic [AW-1:0] emit_r;
  logic [AW-1:0] raddr;
  logic [6:0]    ram_q;
  logic          valid_r;
  logic          is_text_ev;

  logic [2:0] kind_r;
  logic [3:0] code_r;
  logic       rowo_r;
  logic [3:0] col_r;
  logic [6:0] char_r;
  logic       last_r;

  always_comb begin
    stat.is_connect = (in_rx_byte == scfp_pkg::CH_CONNECT);
    stat.is_drive   = (in_rx_byte == scfp_pkg::CH_DRIVE);
    stat.is_text    = (in_rx_byte == scfp_pkg::CH_TEXT);
    stat.is_reset   = (in_rx_byte == scfp_pkg::CH_RESET);
    stat.is_open    = (in_rx_byte == scfp_pkg::CH_OPEN);
    stat.is_close   = (in_rx_byte == scfp_pkg::CH_CLOSE);
    stat.is_semi    = (in_rx_byte == scfp_pkg::CH_SEMI);
    stat.row_ok     = (in_rx_byte == scfp_pkg::CH_ROW1) || (in_rx_byte == scfp_pkg::CH_ROW2);
    stat.high_bit   = (in_rx_byte > scfp_pkg::CH_MAX7);
    stat.code_ok    = (first_r < scfp_pkg::NUM_CODES);
    stat.line_full  = (count_r == LAST_IDX);
    stat.emit_last  = (emit_r == LAST_IDX);
    stat.out_free   = !valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      row_r   <= 1'b0;
      count_r <= '0;
      emit_r  <= '0;
    end else begin
      if (cmd.load_first) begin
        first_r <= in_rx_byte;
      end else if (cmd.load_code) begin
        first_r <= {4'd0, scfp_pkg::drive_decode(first_r, in_rx_byte)};
      end
      if (cmd.load_row) begin
        row_r <= (in_rx_byte == scfp_pkg::CH_ROW2);
      end
      if (cmd.clr_count) begin
        count_r <= '0;
        emit_r  <= '0;
      end else begin
        if (cmd.wr_char) begin
          count_r <= count_r + AW'(1);
        end
        if (cmd.emit_step) begin
          emit_r <= emit_r + AW'(1);
        end
      end
    end
  end

  assign raddr = cmd.emit_step ? emit_r + AW'(1) : emit_r;

  scfp_ram #(
    .WIDTH(7),
    .DEPTH(LINE_CHARS)
  ) u_line_buf (
    .clk   (clk),
    .we    (cmd.wr_char),
    .waddr (count_r),
    .wdata (in_rx_byte[6:0]),
    .raddr (raddr),
    .rdata (ram_q)
  );

  assign is_text_ev = (cmd.out_kind == scfp_pkg::KIND_TEXT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kind_r <= cmd.out_kind;
      code_r <= (cmd.out_kind == scfp_pkg::KIND_DRIVE) ? first_r[3:0] : 4'd0;
      rowo_r <= is_text_ev ? row_r : 1'b0;
      col_r  <= is_text_ev ? 4'(emit_r[CW-1:0]) : 4'd0;
      char_r <= is_text_ev ? ram_q : 7'd0;
      last_r <= is_text_ev ? stat.emit_last : 1'b1;
    end
  end

  assign out_valid      = valid_r;
  assign out_event_kind = kind_r;
  assign out_drive_code = code_r;
  assign out_row_index  = rowo_r;
  assign out_column     = col_r;
  assign out_text_char  = char_r;
  assign out_last       = last_r;

endmodule
`default_nettype wire
